// ===== src/tea_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tea_pkg
// Shared types, constants and the round function of the TEA cipher pipeline.
// ----------------------------------------------------------------------------
package tea_pkg;

  localparam int WORD_W         = 32;
  localparam int KEY_WORDS      = 4;
  localparam int CFG_ADDR_W     = 2;
  localparam int ROUNDS_DEFAULT = 32;

  localparam logic [WORD_W-1:0] DELTA = 32'h9e37_79b9;

  // register indexes of the key words
  localparam logic [CFG_ADDR_W-1:0] REG_KEY0 = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_KEY1 = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_KEY2 = 2'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_KEY3 = 2'd3;

  // direction codes
  localparam logic FUNC_ENC = 1'b0;
  localparam logic FUNC_DEC = 1'b1;

  typedef logic [KEY_WORDS-1:0][WORD_W-1:0] tea_key_t;

  typedef struct packed {
    logic              valid;
    logic              func;
    logic [WORD_W-1:0] a;
    logic [WORD_W-1:0] b;
  } tea_data_t;

  function automatic logic [WORD_W-1:0] tea_mix(input logic [WORD_W-1:0] x,
                                                input logic [WORD_W-1:0] sum,
                                                input logic [WORD_W-1:0] ka,
                                                input logic [WORD_W-1:0] kb);
    tea_mix = ((x << 4) + ka) ^ (x + sum) ^ ((x >> 5) + kb);
  endfunction

endpackage

// ===== src/tea_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tea_cell
// One half of a TEA cycle: updates one word of the block from the other and
// hands the block to the next cell on the following clock.
// ----------------------------------------------------------------------------
module tea_cell
  import tea_pkg::*;
#(
  parameter int ROUNDS = ROUNDS_DEFAULT,
  parameter int IDX    = 0
) (
  input  logic      clk,
  input  logic      rst,
  input  tea_key_t  keys,
  input  tea_data_t din,
  output tea_data_t dout
);

  localparam int ROUND = IDX / 2;
  localparam int HALF  = IDX % 2;

  // running sum seen by this round, per direction
  localparam logic [WORD_W-1:0] SUM_ENC = WORD_W'(64'(DELTA) * 64'(ROUND + 1));
  localparam logic [WORD_W-1:0] SUM_DEC = WORD_W'(64'(DELTA) * 64'(ROUNDS - ROUND));

  logic              upd_a;
  logic [WORD_W-1:0] sum;
  logic [WORD_W-1:0] x;
  logic [WORD_W-1:0] mixed;
  logic [WORD_W-1:0] a_next;
  logic [WORD_W-1:0] b_next;

  always_comb begin
    // first half of encrypt and second half of decrypt touch word a
    upd_a  = (HALF == 0) ^ (din.func == FUNC_DEC);
    sum    = (din.func == FUNC_DEC) ? SUM_DEC : SUM_ENC;
    x      = upd_a ? din.b : din.a;
    mixed  = tea_mix(x, sum,
                     upd_a ? keys[REG_KEY0] : keys[REG_KEY2],
                     upd_a ? keys[REG_KEY1] : keys[REG_KEY3]);
    a_next = din.a;
    b_next = din.b;
    if (upd_a) begin
      a_next = (din.func == FUNC_DEC) ? din.a - mixed : din.a + mixed;
    end else begin
      b_next = (din.func == FUNC_DEC) ? din.b - mixed : din.b + mixed;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.valid <= 1'b0;
    end else begin
      dout.valid <= din.valid;
    end
    dout.func <= din.func;
    dout.a    <= a_next;
    dout.b    <= b_next;
  end

endmodule

// ===== src/tea_block_cipher.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tea_block_cipher
// TEA encrypt/decrypt engine built as a chain of half-round cells.
// ----------------------------------------------------------------------------
// Usage:
//   Load the 128-bit key through cfg_we / cfg_addr / cfg_wdata, one 32-bit
//   word per write, while no block is in flight. Keys reset to zero.
//   A block (func, block_high, block_low) is taken at each rising edge with
//   start high and busy low; busy is never raised, so a new block may enter
//   every cycle.
//   Each block passes through 2*ROUNDS cells, one half cycle of TEA per
//   cell, and its result shows on result_high / result_low with done high
//   for exactly one cycle once the block leaves the last cell. Throughput
//   is one block per clock, since every cell registers its half cycle and
//   takes a new block each clock; results leave in start order.
//   The receiver cannot hold results off; done marks the only cycle in
//   which a result is valid.
//   Synchronous reset empties the chain: blocks in flight are dropped and
//   no done appears until a new block has gone through.
// ----------------------------------------------------------------------------
module tea_block_cipher
  import tea_pkg::*;
#(
  parameter int ROUNDS = ROUNDS_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [WORD_W-1:0]     cfg_wdata,
  input  logic                  start,
  output logic                  busy,
  input  logic                  func,
  input  logic [WORD_W-1:0]     block_high,
  input  logic [WORD_W-1:0]     block_low,
  output logic                  done,
  output logic [WORD_W-1:0]     result_high,
  output logic [WORD_W-1:0]     result_low
);

  localparam int CELLS = 2 * ROUNDS;

  tea_key_t  keys;
  tea_data_t chain [CELLS+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      keys <= '0;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_KEY0: keys[REG_KEY0] <= cfg_wdata;
        REG_KEY1: keys[REG_KEY1] <= cfg_wdata;
        REG_KEY2: keys[REG_KEY2] <= cfg_wdata;
        REG_KEY3: keys[REG_KEY3] <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  always_comb begin
    chain[0].valid = start & ~busy;
    chain[0].func  = func;
    chain[0].a     = block_high;
    chain[0].b     = block_low;
  end

  for (genvar i = 0; i < CELLS; i++) begin : g_cell
    tea_cell #(
      .ROUNDS (ROUNDS),
      .IDX    (i)
    ) u_cell (
      .clk  (clk),
      .rst  (rst),
      .keys (keys),
      .din  (chain[i]),
      .dout (chain[i+1])
    );
  end

  assign done        = chain[CELLS].valid;
  assign result_high = chain[CELLS].a;
  assign result_low  = chain[CELLS].b;

endmodule

// ===== src/tea_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tea_checker
// Port-level checks of the TEA engine: busy never raised, fixed latency and reset behavior.
// ----------------------------------------------------------------------------
module tea_checker
  import tea_pkg::*;
#(
  parameter int ROUNDS = ROUNDS_DEFAULT
) (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done
);

  localparam int LAT = 2 * ROUNDS;

  // accepted transactions still expected at the output
  logic [LAT-1:0] expect_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      expect_q <= '0;
    end else begin
      expect_q <= {expect_q[LAT-2:0], start & ~busy};
    end
  end

  a_never_busy: assert property (@(posedge clk) disable iff (rst) !busy)
    else $error("busy raised");

  a_fixed_latency: assert property (@(posedge clk) disable iff (rst)
    done == expect_q[LAT-1])
    else $error("done does not follow start by the pipeline latency");

  a_reset_flush: assert property (@(posedge clk) rst |=> !done)
    else $error("done right after reset");

endmodule

bind tea_block_cipher tea_checker #(.ROUNDS(ROUNDS)) u_tea_checker (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .done  (done)
);
